FILE: design/speed_pid_pkg.sv
// Shared types and constants for the speed PID throttle/brake controller.
package speed_pid_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [2:0] REG_USE_MANUAL    = 3'd4;
  localparam logic [2:0] REG_MANUAL_SPEED  = 3'd5;
  localparam logic [2:0] REG_TUNNEL_EN     = 3'd6;
  localparam logic [2:0] REG_TUNNEL_SPEED  = 3'd7;

  localparam int MulSteps = 16;   // one multiplier bit per cycle
  localparam int DivSteps = 34;   // quotient bits of |diff| * 2^16

  localparam logic [15:0] FullQ115 = 16'd32768;
  localparam logic signed [23:0] OneQ88 = 24'sd256;
  localparam logic signed [23:0] NegOneQ88 = -24'sd256;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERRPER,   // err * period for the integral
    S_PROP,     // prop_gain * err
    S_INTEG,    // integ_gain * integral
    S_DIV,      // (err - prev) * 2^16 / period
    S_DERIV,    // deriv_gain * quotient
    S_DONE
  } state_t;

endpackage

FILE: design/speed_pid_throttle_brake_top.sv
// Top level of the speed PID controller with throttle/brake split.
//
// Use: one input word per control tick on s_axis (measured and path speed,
// path-valid and in-tunnel flags). A tick that selects a target (tunnel mode
// and in tunnel, or a valid path) runs a PID and yields one output word on
// m_axis: throttle, brake and the saturated PID sum. Other ticks are taken
// and dropped, leaving the state alone.
// Each accepted tick runs four bit-serial multiplies through one shift-add
// unit, a restoring divider (one quotient bit per cycle) and an output
// register load. The single shared shift-add datapath lets only one tick
// be in work at a time: a new word is taken only once the last is done.
// s_axis_tready is high only while idle.
// A finished word sits in the output register; the next tick is accepted
// while it waits. If the receiver still stalls when the following word is
// done, the block holds in its last state until the register frees up.
// Reset (rst, synchronous) restores register defaults, clears the integral,
// the previous error and the output valid flag.
// Config writes (cfg_we) are registered; write only while idle.
module speed_pid_throttle_brake_top
  import speed_pid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // measured_speed[15:0], path_speed[31:16]
  input  logic [1:0]  s_axis_tuser,   // path_valid[0], in_tunnel[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // throttle[15:0], brake[31:16], pid_output[55:32]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // config registers
  logic [15:0] prop_gain, integ_gain, deriv_gain, sample_period;
  logic        use_manual_speed, tunnel_mode_enable;
  logic [14:0] manual_speed, tunnel_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain          <= 16'd256;
      integ_gain         <= 16'd0;
      deriv_gain         <= 16'd0;
      sample_period      <= 16'd655;
      use_manual_speed   <= 1'b0;
      manual_speed       <= 15'd0;
      tunnel_mode_enable <= 1'b0;
      tunnel_speed       <= 15'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:     prop_gain          <= cfg_data;
        REG_INTEG_GAIN:    integ_gain         <= cfg_data;
        REG_DERIV_GAIN:    deriv_gain         <= cfg_data;
        REG_SAMPLE_PERIOD: sample_period      <= cfg_data;
        REG_USE_MANUAL:    use_manual_speed   <= cfg_data[0];
        REG_MANUAL_SPEED:  manual_speed       <= cfg_data[14:0];
        REG_TUNNEL_EN:     tunnel_mode_enable <= cfg_data[0];
        REG_TUNNEL_SPEED:  tunnel_speed       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // zero period behaves as one
  logic [15:0] period_eff;
  assign period_eff = (sample_period == 16'd0) ? 16'd1 : sample_period;

  // input unpack and target select
  logic signed [15:0] measured_speed, path_speed;
  logic               path_valid, in_tunnel, tunnel_hit, take_tick;
  logic signed [17:0] target, err_in;

  assign measured_speed = s_axis_tdata[15:0];
  assign path_speed     = s_axis_tdata[31:16];
  assign path_valid     = s_axis_tuser[0];
  assign in_tunnel      = s_axis_tuser[1];
  assign tunnel_hit     = tunnel_mode_enable && in_tunnel;
  assign take_tick      = tunnel_hit || path_valid;

  always_comb begin
    if (tunnel_hit)            target = {3'b000, tunnel_speed};
    else if (use_manual_speed) target = {3'b000, manual_speed};
    else                       target = {{2{path_speed[15]}}, path_speed};
  end
  assign err_in = target - {{2{measured_speed[15]}}, measured_speed};

  // state
  state_t state, state_next;
  logic [5:0] cnt;
  logic       mul_last, div_last;
  logic       out_valid;

  assign mul_last = (cnt == 6'(MulSteps - 1));
  assign div_last = (cnt == 6'(DivSteps - 1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_axis_tvalid && take_tick) state_next = S_ERRPER;
      S_ERRPER: if (mul_last) state_next = S_PROP;
      S_PROP:   if (mul_last) state_next = S_INTEG;
      S_INTEG:  if (mul_last) state_next = S_DIV;
      S_DIV:    if (div_last) state_next = S_DERIV;
      S_DERIV:  if (mul_last) state_next = S_DONE;
      S_DONE:   if (!out_valid || m_axis_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
  end

  // datapath
  logic signed [17:0] err, prev_err;
  logic signed [31:0] integ;
  logic signed [25:0] p_val;
  logic signed [31:0] i_val;
  logic signed [51:0] acc, ma, acc_sum;
  logic        [15:0] mb;
  logic        [15:0] rem;
  logic        [33:0] dq;
  logic               dsign, low_path, low_path_in;
  logic signed [23:0] pid;

  assign low_path_in = (path_speed < 16'sd256);
  assign acc_sum = mb[0] ? (acc + ma) : acc;

  // integral update
  logic signed [32:0] integ_sum;
  logic signed [31:0] integ_sat;
  assign integ_sum = {integ[31], integ} + {{7{acc_sum[33]}}, acc_sum[33:8]};
  always_comb begin
    if (integ_sum > 33'sh7FFF_FFFF)       integ_sat = 32'sh7FFF_FFFF;
    else if (integ_sum < -33'sh8000_0000) integ_sat = 32'sh8000_0000;
    else                                  integ_sat = integ_sum[31:0];
  end

  // divider step
  logic signed [18:0] diff;
  logic        [17:0] dmag;
  logic        [16:0] shifted;
  logic        [17:0] trial;
  logic        [33:0] dq_step, q_mag;
  logic signed [34:0] q_signed;
  assign diff    = {err[17], err} - {prev_err[17], prev_err};
  assign dmag    = diff[18] ? 18'(-diff) : diff[17:0];
  assign shifted = {rem, dq[33]};
  assign trial   = {1'b0, shifted} - {2'b00, period_eff};
  assign dq_step = {dq[32:0], ~trial[17]};
  assign q_mag   = dq_step;
  assign q_signed = dsign ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  // final PID sum
  logic signed [44:0] pid_sum;
  logic signed [23:0] pid_sat;
  assign pid_sum = {{19{p_val[25]}}, p_val} + {{13{i_val[31]}}, i_val}
                 + {acc_sum[51], acc_sum[51:8]};
  always_comb begin
    if (pid_sum > 45'sd8388607)       pid_sat = 24'sh7F_FFFF;
    else if (pid_sum < -45'sd8388608) pid_sat = 24'sh80_0000;
    else                              pid_sat = pid_sum[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      integ    <= '0;
      prev_err <= '0;
      cnt      <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && take_tick) begin
            err      <= err_in;
            low_path <= low_path_in;
            ma       <= {{34{err_in[17]}}, err_in};
            mb       <= period_eff;
            acc      <= '0;
            cnt      <= '0;
          end
        end
        S_ERRPER, S_PROP, S_INTEG, S_DERIV: begin
          if (mul_last) begin
            acc <= '0;
            cnt <= '0;
            case (state)
              S_ERRPER: begin
                integ <= integ_sat;
                ma    <= {{34{err[17]}}, err};
                mb    <= prop_gain;
              end
              S_PROP: begin
                p_val <= acc_sum[33:8];
                ma    <= {{20{integ[31]}}, integ};
                mb    <= integ_gain;
              end
              S_INTEG: begin
                i_val    <= acc_sum[47:16];
                dsign    <= diff[18];
                dq       <= {dmag[17:0], 16'd0};
                rem      <= '0;
                prev_err <= err;
              end
              default: pid <= pid_sat;
            endcase
          end else begin
            acc <= acc_sum;
            ma  <= ma <<< 1;
            mb  <= mb >> 1;
            cnt <= cnt + 6'd1;
          end
        end
        S_DIV: begin
          rem <= trial[17] ? shifted[15:0] : trial[15:0];
          dq  <= dq_step;
          if (div_last) begin
            cnt <= '0;
            acc <= '0;
            ma  <= {{17{q_signed[34]}}, q_signed};
            mb  <= deriv_gain;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // throttle / brake split
  logic [15:0] thr, brk;
  always_comb begin
    if (pid > OneQ88) begin
      thr = FullQ115; brk = 16'd0;
    end else if (pid > 24'sd0) begin
      thr = {pid[8:0], 7'd0}; brk = 16'd0;
    end else if (pid > NegOneQ88) begin
      thr = 16'd0; brk = {9'(-pid), 7'd0};
    end else begin
      thr = 16'd0; brk = FullQ115;
    end
    if (low_path) begin
      thr = 16'd0; brk = FullQ115;
    end
  end

  // output register
  logic [55:0] out_word;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
        out_word  <= {pid, brk, thr};
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;

  // checks
  a_rst_clears_valid: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
  a_split_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] == 16'd0 || m_axis_tdata[31:16] == 16'd0))
    else $error("throttle and brake both active");
  a_split_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= FullQ115 && m_axis_tdata[31:16] <= FullQ115))
    else $error("throttle or brake beyond full scale");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < period_eff))
    else $error("divider remainder out of range");

endmodule

FILE: tb/speed_pid_checker.sv
// Checker for the speed PID controller: tracks registers, predicts outputs, compares.
module speed_pid_checker
  import speed_pid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] pid;
    logic [15:0] brake;
    logic [15:0] throttle;
  } cmd_t;

  longint kp, ki, kd, period_reg, manual_spd, tunnel_spd;
  logic   manual_on, tunnel_on;
  longint integ_acc, last_err;
  cmd_t   cmd_q[$];

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Returns 1 and the command when the tick selects a target; updates PID state.
  function automatic bit control_tick(logic [31:0] data, logic [1:0] flags, output cmd_t c);
    longint meas, pspd, target, err, per, p, i, d, pid;
    meas = longint'($signed(data[15:0]));
    pspd = longint'($signed(data[31:16]));
    if (tunnel_on && flags[1]) target = tunnel_spd;
    else if (flags[0]) target = manual_on ? manual_spd : pspd;
    else return 0;
    per = (period_reg == 0) ? 1 : period_reg;
    err = target - meas;
    p = (kp * err) >>> 8;
    integ_acc = sat(integ_acc + ((err * per) >>> 8), -64'sd2147483648, 64'sd2147483647);
    i = (ki * integ_acc) >>> 16;
    d = ((err - last_err) * 65536) / per;   // truncates toward zero
    d = (kd * d) >>> 8;
    last_err = err;
    pid = sat(p + i + d, -64'sd8388608, 64'sd8388607);
    c.pid = pid[23:0];
    if (pid > 256) begin
      c.throttle = FullQ115; c.brake = 16'd0;
    end else if (pid > 0) begin
      c.throttle = 16'(pid * 128); c.brake = 16'd0;
    end else if (pid > -256) begin
      c.throttle = 16'd0; c.brake = 16'(-pid * 128);
    end else begin
      c.throttle = 16'd0; c.brake = FullQ115;
    end
    // low path speed always forces full brake
    if (pspd < 256) begin
      c.throttle = 16'd0; c.brake = FullQ115;
    end
    return 1;
  endfunction

  assign pending = cmd_q.size();

  always @(posedge clk) begin
    cmd_t c, got;
    if (rst) begin
      kp = 256; ki = 0; kd = 0; period_reg = 655;
      manual_on = 0; manual_spd = 0; tunnel_on = 0; tunnel_spd = 0;
      integ_acc = 0; last_err = 0;
      cmd_q.delete();
      fails = 0;
      words_checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:     kp = longint'(cfg_data);
          REG_INTEG_GAIN:    ki = longint'(cfg_data);
          REG_DERIV_GAIN:    kd = longint'(cfg_data);
          REG_SAMPLE_PERIOD: period_reg = longint'(cfg_data);
          REG_USE_MANUAL:    manual_on = cfg_data[0];
          REG_MANUAL_SPEED:  manual_spd = longint'(cfg_data[14:0]);
          REG_TUNNEL_EN:     tunnel_on = cfg_data[0];
          REG_TUNNEL_SPEED:  tunnel_spd = longint'(cfg_data[14:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        if (control_tick(s_axis_tdata, s_axis_tuser, c)) cmd_q.push_back(c);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (cmd_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word %h", $time, m_axis_tdata);
        end else begin
          c = cmd_q.pop_front();
          words_checked++;
          if (got.throttle !== c.throttle) begin
            fails++;
            $display("%0t: throttle exp %0d got %0d", $time, c.throttle, got.throttle);
          end
          if (got.brake !== c.brake) begin
            fails++;
            $display("%0t: brake exp %0d got %0d", $time, c.brake, got.brake);
          end
          if (got.pid !== c.pid) begin
            fails++;
            $display("%0t: pid exp %0d got %0d", $time, $signed(c.pid), $signed(got.pid));
          end
        end
      end
    end
  end
endmodule

FILE: tb/speed_pid_throttle_brake_top_tb.sv
// Testbench top for the speed PID controller: stimulus, config phases and verdict.
module speed_pid_throttle_brake_top_tb;
  import speed_pid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CycleLimit = 1500000;
  localparam int     DrainWait  = 200;   // covers one full tick with margin

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;        // measured_speed[15:0], path_speed[31:16]
  logic [1:0]  s_axis_tuser = '0;        // path_valid[0], in_tunnel[1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;             // throttle[15:0], brake[31:16], pid_output[55:32]
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int     fails, pending, words_checked;
  int     ticks_sent = 0;
  longint cycles = 0;
  bit     hold_req = 0;    // ask the receiver for one long stall
  bit     quiet = 0;       // both sides run with no gaps

  // shadow of the target registers so stimulus can aim near the setpoint
  int manual_spd = 0, tunnel_spd = 0;
  bit manual_on = 0, tunnel_on = 0;

  speed_pid_throttle_brake_top uut (.*);

  speed_pid_checker chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we, .cfg_index, .cfg_data,
    .fails, .pending, .words_checked
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, occasional long hold-off
  always begin
    int n;
    if (rst) begin
      @(posedge clk);
    end else begin
      if (hold_req) begin
        m_axis_tready <= 0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 10);
        if (n > 0) begin
          m_axis_tready <= 0;
          repeat (n) @(posedge clk);
        end
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // caller lowers cfg_we after the last write
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_USE_MANUAL:   manual_on = val[0];
      REG_MANUAL_SPEED: manual_spd = val[14:0];
      REG_TUNNEL_EN:    tunnel_on = val[0];
      REG_TUNNEL_SPEED: tunnel_spd = val[14:0];
      default: ;
    endcase
  endtask

  // one control tick; valid stays high across back-to-back words
  task automatic send_tick(logic [15:0] meas, logic [15:0] pspd, logic valid, logic tun);
    int n;
    n = quiet ? 0 : $urandom_range(0, 10);
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {pspd, meas};
    s_axis_tuser <= {tun, valid};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    ticks_sent++;
  endtask

  // let every expected word land and any result-less tick finish before config
  task automatic drain();
    if (s_axis_tvalid) s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] kp, ki, kd, per, logic man, logic [15:0] mspd,
                         logic ten, logic [15:0] tspd);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_SAMPLE_PERIOD, per);
    write_reg(REG_USE_MANUAL, {15'd0, man});
    write_reg(REG_MANUAL_SPEED, mspd);
    write_reg(REG_TUNNEL_EN, {15'd0, ten});
    write_reg(REG_TUNNEL_SPEED, tspd);
    cfg_we <= 0;
  endtask

  // random tick, mostly aimed near the active target so the split is exercised
  task automatic random_tick();
    int r, tgt;
    logic [15:0] meas, pspd;
    logic valid, tun;
    r = $urandom_range(0, 99);
    valid = (r < 85);
    tun = ($urandom_range(0, 3) == 0);
    pspd = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16000));
    tgt = (tunnel_on && tun) ? tunnel_spd : (manual_on ? manual_spd : int'($signed(pspd)));
    if ($urandom_range(0, 3) == 0) meas = 16'($urandom);
    else meas = 16'(tgt + int'($urandom_range(0, 1200)) - 600);
    send_tick(meas, pspd, valid, tun);
  endtask

  initial begin
    int phase;
    int errs[11];
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, each split region, tunnel and dropped ticks, low path speed
    set_all(256, 0, 0, 655, 0, 0, 1, 16'h2000);
    send_tick(16'h7FFF, 16'h8000, 1, 0);
    send_tick(16'h8000, 16'h7FFF, 1, 0);
    send_tick(16'h0000, 16'h00FF, 1, 0);     // just below 1 kph
    send_tick(16'h0000, 16'h0100, 1, 0);     // exactly 1 kph
    send_tick(16'h1000, 16'h4000, 0, 0);     // no tunnel, no path: dropped
    send_tick(16'h2000, 16'h4000, 0, 1);     // tunnel target without a path
    send_tick(16'h1F00, 16'h0000, 0, 1);     // tunnel, low path speed
    errs = '{300, 257, 256, 100, 1, 0, -1, -100, -255, -256, -300};
    foreach (errs[k]) send_tick(16'(16'h4000 - errs[k]), 16'h4000, 1, 0);
    send_tick(16'hFFFF, 16'hFFFF, 1, 1);
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_all(65535, 65535, 65535, 1, 1, 16'h7FFF, 1, 16'h7FFF);
        1: set_all(0, 0, 0, 65535, 0, 0, 0, 0);
        2: set_all(128, 2, 1, 0, 0, 16'h1000, 1, 16'h1800);   // zero period acts as one
        3: set_all(300, 40, 5, 655, 1, 16'h2000, 0, 16'h0100);
        default: set_all(16'($urandom_range(0, 600)), 16'($urandom_range(0, 200)),
                         16'($urandom_range(0, 50)), 16'($urandom_range(1, 4000)),
                         1'($urandom), 16'($urandom_range(0, 32767)),
                         1'($urandom), 16'($urandom_range(0, 32767)));
      endcase
      quiet = (phase == 5);
      if (phase == 3) hold_req = 1;   // receiver stalls long while ticks keep coming
      repeat (190) random_tick();
      drain();
    end
    quiet = 0;

    $display("ran %0d ticks over 9 register settings, %0d command words checked",
             ticks_sent, words_checked);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: speed_pid_throttle_brake_top.f
design/speed_pid_pkg.sv
design/speed_pid_throttle_brake_top.sv
tb/speed_pid_checker.sv
tb/speed_pid_throttle_brake_top_tb.sv
